[hdl/dtbs_pkg.sv]
// shared types and constants for the date and time button setter
// no dependencies; imported by dtbs_step and date_time_button_setter_core
package dtbs_pkg;

	// stream widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 4;

	// limits of the edited fields
	localparam logic [3:0] MONTH_MIN  = 4'd1;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [4:0] DAY_MIN    = 5'd1;
	localparam logic [4:0] DAY_LONG   = 5'd31;
	localparam logic [4:0] DAY_SHORT  = 5'd30;
	localparam logic [4:0] DAY_FEB_LY = 5'd29;
	localparam logic [4:0] DAY_FEB    = 5'd28;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;

	// month numbers that need special day limits
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;

	// button codes carried in the input tuser
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DEC   = 2'd1,
		KIND_NEXT  = 2'd2,
		KIND_INC   = 2'd3
	} kind_t;

	// field selection codes
	typedef enum logic [2:0] {
		FLD_NONE   = 3'd0,
		FLD_YEAR   = 3'd1,
		FLD_MONTH  = 3'd2,
		FLD_DAY    = 3'd3,
		FLD_HOUR   = 3'd4,
		FLD_MINUTE = 3'd5
	} field_t;

	// loaded date and time
	typedef struct packed {
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
	} date_time_t;

	// full editor state
	typedef struct packed {
		logic       editing;
		field_t     field_sel;
		date_time_t dt;
	} edit_state_t;

	// days in a month, month already clamped to 1..12
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic [7:0] year);
		logic [4:0] top;
		top = DAY_LONG;
		if (month == MON_APR || month == MON_JUN || month == MON_SEP || month == MON_NOV) begin
			top = DAY_SHORT;
		end else if (month == MON_FEB) begin
			top = (year[1:0] == 2'd0) ? DAY_FEB_LY : DAY_FEB;
		end
		return top;
	endfunction

endpackage

[hdl/dtbs_step.sv]
// next-state logic of the date and time button setter: one button beat
// applied to the editor state, then clamping of month, day, hour and minute
// depends on dtbs_pkg
module dtbs_step (
	input  dtbs_pkg::edit_state_t cur,
	input  dtbs_pkg::kind_t       kind,
	input  dtbs_pkg::date_time_t  load,
	output dtbs_pkg::edit_state_t nxt,
	output logic                  commit
);
	import dtbs_pkg::*;

	logic       editing;
	field_t     fsel;
	logic [7:0] year;
	logic [3:0] month;
	logic [5:0] day;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [4:0] top;
	logic       up;

	// apply the button, then clamp
	always_comb begin
		editing = cur.editing;
		fsel    = cur.field_sel;
		year    = cur.dt.year;
		month   = cur.dt.month;
		day     = {1'b0, cur.dt.day};
		hour    = cur.dt.hour;
		minute  = cur.dt.minute;
		commit  = 1'b0;
		up      = (kind == KIND_INC);

		unique case (kind)
			KIND_START: begin
				editing = 1'b1;
				fsel    = FLD_YEAR;
				year    = load.year;
				month   = load.month;
				day     = {1'b0, load.day};
				hour    = load.hour;
				minute  = load.minute;
			end
			KIND_NEXT: begin
				if (cur.editing) begin
					if (cur.field_sel >= FLD_MINUTE) begin
						fsel    = FLD_NONE;
						editing = 1'b0;
						commit  = 1'b1;
					end else begin
						fsel = field_t'(cur.field_sel + 3'd1);
					end
				end
			end
			KIND_DEC, KIND_INC: begin
				if (cur.editing) begin
					case (cur.field_sel)
						FLD_YEAR: year = up ? year + 8'd1 : year - 8'd1;
						FLD_MONTH: begin
							if (up) month = month + 4'd1;
							else if (month != 4'd0) month = month - 4'd1;
						end
						FLD_DAY: begin
							if (up) day = day + 6'd1;
							else if (day != 6'd0) day = day - 6'd1;
						end
						FLD_HOUR: begin
							if (up) begin
								if (hour < HOUR_MAX) hour = hour + 5'd1;
							end else if (hour != 5'd0) begin
								hour = hour - 5'd1;
							end
						end
						FLD_MINUTE: begin
							if (up) begin
								if (minute < MINUTE_MAX) minute = minute + 6'd1;
							end else if (minute != 6'd0) begin
								minute = minute - 6'd1;
							end
						end
						default: ;
					endcase
				end
			end
		endcase

		// clamp month, then day to the month length, then hour and minute
		if (month == 4'd0) month = MONTH_MIN;
		if (month > MONTH_MAX) month = MONTH_MAX;
		top = month_days(month, year);
		if (day == 6'd0) day = {1'b0, DAY_MIN};
		if (day > {1'b0, top}) day = {1'b0, top};
		if (hour > HOUR_MAX) hour = HOUR_MAX;
		if (minute > MINUTE_MAX) minute = MINUTE_MAX;
		if (!editing) fsel = FLD_NONE;

		nxt.editing   = editing;
		nxt.field_sel = fsel;
		nxt.dt.year   = year;
		nxt.dt.month  = month;
		nxt.dt.day    = day[4:0];
		nxt.dt.hour   = hour;
		nxt.dt.minute = minute;
	end

endmodule

[hdl/date_time_button_setter_core.sv]
// top level of the date and time button setter: editor state register,
// next-state logic and the output register of the result stream
// depends on dtbs_pkg and dtbs_step
//
// channel | direction | contents
// s_*     | in        | tdata: year, month, day, hour, minute; tuser: button kind
// m_*     | out       | tdata: year, month, day, hour, minute; tuser: field, commit
//
// one input beat per cycle unless the output stalls; its result appears in
// the cycle after acceptance; the editor state is updated in the cycle the
// beat is accepted, so a new beat can follow in the next cycle
// reset puts the editor idle with 2000-01-01 00:00 and no field selected
// a stalled output holds its beat; input is taken when the output register
// is empty or drains in the same cycle
module date_time_button_setter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [7:0] load_year, [11:8] load_month, [16:12] load_day,
	// [21:17] load_hour, [27:22] load_minute, rest zero
	input  logic [dtbs_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] kind
	input  logic [dtbs_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] cur_year, [11:8] cur_month, [16:12] cur_day,
	// [21:17] cur_hour, [27:22] cur_minute, rest zero
	output logic [dtbs_pkg::OUT_DATA_W-1:0]    m_tdata,
	// [2:0] selected_field, [3] commit
	output logic [dtbs_pkg::OUT_USER_W-1:0]    m_tuser
);
	import dtbs_pkg::*;

	localparam int DT_W = $bits(date_time_t);

	edit_state_t state_q;
	edit_state_t state_nxt;
	date_time_t  load;
	logic        commit_nxt;
	logic        in_beat;
	logic        m_tvalid_q;
	date_time_t  out_dt_q;
	field_t      out_fsel_q;
	logic        out_commit_q;

	// handshake
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;

	// unpack the input beat
	assign load = s_tdata[DT_W-1:0];

	dtbs_step u_step (
		.cur    (state_q),
		.kind   (kind_t'(s_tuser)),
		.load   (load),
		.nxt    (state_nxt),
		.commit (commit_nxt)
	);

	// editor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.editing   <= 1'b0;
			state_q.field_sel <= FLD_NONE;
			state_q.dt.year   <= 8'd0;
			state_q.dt.month  <= MONTH_MIN;
			state_q.dt.day    <= DAY_MIN;
			state_q.dt.hour   <= 5'd0;
			state_q.dt.minute <= 6'd0;
		end else if (in_beat) begin
			state_q <= state_nxt;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_beat) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_dt_q     <= state_nxt.dt;
			out_fsel_q   <= state_nxt.field_sel;
			out_commit_q <= commit_nxt;
		end
	end

	// pack the result beat
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W-DT_W){1'b0}}, out_dt_q};
	assign m_tuser  = {out_commit_q, out_fsel_q};

endmodule
